FILE: design/fbdr_pkg.sv
// fbdr_pkg: types and constants shared by the dirty rectangle block
// item structs for both channels, the encoder result and register indexes
// no dependencies
package fbdr_pkg;

  localparam int PIX_PER_BYTE = 8;
  localparam int LAST_BIT_IDX = PIX_PER_BYTE - 1;

  localparam int COL_CNT_W = 7;
  localparam int COORD_W   = 10;
  localparam int SPAN_W    = 11;
  localparam int RB_W      = 8;
  localparam int RC_W      = 11;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 11;

  // hard limits of the tracker widths
  localparam int RB_LIMIT = 128;
  localparam int RC_LIMIT = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 1'b1;

  typedef struct packed {
    logic [7:0] old_byte;
    logic [7:0] new_byte;
  } in_item_t;

  typedef struct packed {
    logic               any_change;
    logic [COORD_W-1:0] left_x;
    logic [COORD_W-1:0] top_y;
    logic [SPAN_W-1:0]  box_width;
    logic [SPAN_W-1:0]  box_height;
  } out_item_t;

  // changed pixels of one byte, positions counted from the leftmost pixel
  typedef struct packed {
    logic       changed;
    logic [2:0] first_pos;
    logic [2:0] last_pos;
  } enc_t;

endpackage

FILE: design/fbdr_chan_if.sv
// fbdr_chan_if: valid/ready channel carrying one item per handshake
// payload type is a parameter; types come from fbdr_pkg
interface fbdr_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/fbdr_encode.sv
// fbdr_encode: xor of old and new byte and priority encoders for the
// first and last changed pixel; uses fbdr_pkg
module fbdr_encode (
  input  fbdr_pkg::in_item_t item,
  output fbdr_pkg::enc_t     enc
);
  logic [7:0] diff;

  assign diff = item.old_byte ^ item.new_byte;

  always_comb begin
    enc.changed   = |diff;
    enc.first_pos = 3'(fbdr_pkg::LAST_BIT_IDX);
    enc.last_pos  = '0;
    // msb wins for the first pixel
    for (int i = 0; i < fbdr_pkg::PIX_PER_BYTE; i++) begin
      if (diff[i]) begin
        enc.first_pos = 3'(fbdr_pkg::LAST_BIT_IDX - i);
      end
    end
    // lsb wins for the last pixel
    for (int i = fbdr_pkg::LAST_BIT_IDX; i >= 0; i--) begin
      if (diff[i]) begin
        enc.last_pos = 3'(fbdr_pkg::LAST_BIT_IDX - i);
      end
    end
  end
endmodule

FILE: design/fbdr_track.sv
// fbdr_track: byte and row counters, running bounds of changed pixels,
// end of frame detection and the rectangle result; uses fbdr_pkg
module fbdr_track (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  fbdr_pkg::enc_t                enc,
  input  logic [fbdr_pkg::RB_W-1:0]     row_bytes,
  input  logic [fbdr_pkg::RC_W-1:0]     row_count,
  output logic                          emit,
  output fbdr_pkg::out_item_t           result
);
  localparam logic [fbdr_pkg::COORD_W-1:0] COORD_ONES = '1;

  logic [fbdr_pkg::COL_CNT_W-1:0] col_cnt_r, col_cnt_nxt;
  logic [fbdr_pkg::COORD_W-1:0]   row_pos_r, row_pos_nxt;
  logic [fbdr_pkg::COORD_W-1:0]   min_col_r, min_col_nxt;
  logic [fbdr_pkg::COORD_W-1:0]   max_col_r, max_col_nxt;
  logic [fbdr_pkg::COORD_W-1:0]   min_row_r, min_row_nxt;
  logic [fbdr_pkg::COORD_W-1:0]   max_row_r, max_row_nxt;
  logic                           seen_r, seen_nxt;

  logic [fbdr_pkg::COORD_W-1:0] base, lo, hi;
  logic [fbdr_pkg::COORD_W-1:0] min_col_upd, max_col_upd, min_row_upd, max_row_upd;
  logic                         seen_upd;
  logic                         zero_size, row_end, frame_end;
  logic [fbdr_pkg::RB_W-1:0]    col_inc;
  logic [fbdr_pkg::RC_W-1:0]    row_inc;

  always_comb begin
    // low three bits of base are zero, so the add is an or
    base = {col_cnt_r, 3'b000};
    lo   = base | fbdr_pkg::COORD_W'(enc.first_pos);
    hi   = base | fbdr_pkg::COORD_W'(enc.last_pos);

    min_col_upd = (enc.changed && lo < min_col_r) ? lo : min_col_r;
    max_col_upd = (enc.changed && hi > max_col_r) ? hi : max_col_r;
    min_row_upd = (enc.changed && row_pos_r < min_row_r) ? row_pos_r : min_row_r;
    max_row_upd = (enc.changed && row_pos_r > max_row_r) ? row_pos_r : max_row_r;
    seen_upd    = seen_r | enc.changed;

    col_inc   = {1'b0, col_cnt_r} + 8'd1;
    row_inc   = {1'b0, row_pos_r} + 11'd1;
    zero_size = (row_bytes == '0) || (row_count == '0);
    row_end   = (col_inc >= row_bytes);
    frame_end = row_end && (row_inc >= row_count);
    emit      = zero_size || frame_end;

    result = '0;
    if (!zero_size && seen_upd) begin
      result.any_change = 1'b1;
      result.left_x     = min_col_upd;
      result.top_y      = min_row_upd;
      result.box_width  = (max_col_upd >= min_col_upd) ?
                          ({1'b0, max_col_upd} - {1'b0, min_col_upd} + 11'd1) : '0;
      result.box_height = (max_row_upd >= min_row_upd) ?
                          ({1'b0, max_row_upd} - {1'b0, min_row_upd} + 11'd1) : '0;
    end

    col_cnt_nxt = col_cnt_r;
    row_pos_nxt = row_pos_r;
    min_col_nxt = min_col_r;
    max_col_nxt = max_col_r;
    min_row_nxt = min_row_r;
    max_row_nxt = max_row_r;
    seen_nxt    = seen_r;
    if (step) begin
      if (emit) begin
        col_cnt_nxt = '0;
        row_pos_nxt = '0;
        min_col_nxt = COORD_ONES;
        max_col_nxt = '0;
        min_row_nxt = COORD_ONES;
        max_row_nxt = '0;
        seen_nxt    = 1'b0;
      end else begin
        min_col_nxt = min_col_upd;
        max_col_nxt = max_col_upd;
        min_row_nxt = min_row_upd;
        max_row_nxt = max_row_upd;
        seen_nxt    = seen_upd;
        if (row_end) begin
          col_cnt_nxt = '0;
          row_pos_nxt = row_inc[fbdr_pkg::COORD_W-1:0];
        end else begin
          col_cnt_nxt = col_inc[fbdr_pkg::COL_CNT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_pos_r <= '0;
      min_col_r <= COORD_ONES;
      max_col_r <= '0;
      min_row_r <= COORD_ONES;
      max_row_r <= '0;
      seen_r    <= 1'b0;
    end else begin
      col_cnt_r <= col_cnt_nxt;
      row_pos_r <= row_pos_nxt;
      min_col_r <= min_col_nxt;
      max_col_r <= max_col_nxt;
      min_row_r <= min_row_nxt;
      max_row_r <= max_row_nxt;
      seen_r    <= seen_nxt;
    end
  end
endmodule

FILE: design/framebuffer_dirty_rectangle.sv
// framebuffer_dirty_rectangle: bounding box of changed pixels between two
// 1 bpp frames; uses fbdr_pkg, fbdr_chan_if, fbdr_encode, fbdr_track
//
//   port     direction  carries
//   in_ch    sink       old_byte, new_byte: one byte pair per item
//   out_ch   source     any_change, left_x, top_y, box_width, box_height
//   cfg_*    write      row_bytes (index 0), row_count (index 1)
//
// one item per cycle unless an item that ends a frame waits on a stalled
// output, which also holds back the input; other items never wait. an item
// sits in the input register, its result, if the frame ends there, in the
// output register. reset is synchronous: counters and bounds clear, sizes
// return to 50 bytes by 480 rows. writes clamp, row_bytes on its low 8 bits.
module framebuffer_dirty_rectangle #(
  parameter int MAX_ROW_BYTES = 128,
  parameter int MAX_ROWS      = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  fbdr_chan_if.sink                         in_ch,
  fbdr_chan_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [fbdr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fbdr_pkg::CFG_DATA_W-1:0]   cfg_data
);
  localparam logic [fbdr_pkg::RB_W-1:0] RB_CAP =
    fbdr_pkg::RB_W'((MAX_ROW_BYTES < fbdr_pkg::RB_LIMIT) ? MAX_ROW_BYTES : fbdr_pkg::RB_LIMIT);
  localparam logic [fbdr_pkg::RC_W-1:0] RC_CAP =
    fbdr_pkg::RC_W'((MAX_ROWS < fbdr_pkg::RC_LIMIT) ? MAX_ROWS : fbdr_pkg::RC_LIMIT);
  localparam logic [fbdr_pkg::RB_W-1:0] RB_RESET = (RB_CAP < 8'd50) ? RB_CAP : 8'd50;
  localparam logic [fbdr_pkg::RC_W-1:0] RC_RESET = (RC_CAP < 11'd480) ? RC_CAP : 11'd480;

  logic [fbdr_pkg::RB_W-1:0] row_bytes_r, row_bytes_nxt;
  logic [fbdr_pkg::RC_W-1:0] row_count_r, row_count_nxt;

  fbdr_pkg::in_item_t  in_r;
  logic                s1_valid_r, s1_valid_nxt;
  fbdr_pkg::enc_t      enc;
  logic                emit, s1_fire, in_fire;
  fbdr_pkg::out_item_t result;
  fbdr_pkg::out_item_t out_r;
  logic                out_valid_r, out_valid_nxt;

  // row_count is saturated on the way in, row_bytes only from its low 8 bits
  always_comb begin
    row_bytes_nxt = row_bytes_r;
    row_count_nxt = row_count_r;
    if (cfg_we) begin
      case (cfg_index)
        fbdr_pkg::CFG_ROW_BYTES: begin
          row_bytes_nxt = (cfg_data[fbdr_pkg::RB_W-1:0] > RB_CAP) ?
                          RB_CAP : cfg_data[fbdr_pkg::RB_W-1:0];
        end
        fbdr_pkg::CFG_ROW_COUNT: begin
          row_count_nxt = (cfg_data > RC_CAP) ? RC_CAP : cfg_data;
        end
        default: begin
          row_bytes_nxt = row_bytes_r;
        end
      endcase
    end
  end

  fbdr_encode u_enc (
    .item (in_r),
    .enc  (enc)
  );

  fbdr_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_fire),
    .enc       (enc),
    .row_bytes (row_bytes_r),
    .row_count (row_count_r),
    .emit      (emit),
    .result    (result)
  );

  // an item that ends a frame waits only if the output register is full and not read
  assign s1_fire     = s1_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r <= RB_RESET;
      row_count_r <= RC_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_bytes_r <= row_bytes_nxt;
      row_count_r <= row_count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_r <= in_ch.data;
    end
    if (s1_fire && emit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;
endmodule

FILE: design/fbdr_checker.sv
// fbdr_checker: port level checks on the result channel of the block
// bound to framebuffer_dirty_rectangle; uses fbdr_pkg
module fbdr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input fbdr_pkg::out_item_t out_data
);
  // no result straight after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // an unchanged frame reports an empty rectangle
  a_no_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.any_change |->
      out_data.left_x == '0 && out_data.top_y == '0 &&
      out_data.box_width == '0 && out_data.box_height == '0)
    else $error("empty frame with non-zero rectangle");

  // a changed frame covers at least one pixel
  a_change_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.any_change |->
      out_data.box_width != '0 && out_data.box_height != '0)
    else $error("changed frame with empty rectangle");
endmodule

bind framebuffer_dirty_rectangle fbdr_checker u_fbdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
